// ===== rtl/cba_pkg.sv =====
// shared types, constants and the byte index table of the code bitmap allocator
// no dependencies; used by the top level and the port checker
package cba_pkg;

	// bitmap geometry
	localparam int TABLE_BYTES = 128;
	localparam int CODE_W      = 10;
	localparam int BIT_W       = 3;
	localparam int CODE_BYTES  = 1 << (CODE_W - BIT_W);
	localparam int BYTE_W      = 8;
	localparam int ADDR_W      = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;

	// bytes that a code can ever reach: scan and clear cover exactly these
	localparam int SCAN_BYTES  = (TABLE_BYTES < CODE_BYTES) ? TABLE_BYTES : CODE_BYTES;
	localparam int SCAN_W      = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

	localparam logic [BYTE_W-1:0] FULL_BYTE = {BYTE_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_CHECK   = 2'd0,
		REQ_RESERVE = 2'd1,
		REQ_FREE    = 2'd2,
		REQ_ALLOC   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_ALREADY = 2'd1,
		STAT_NOT_RES = 2'd2,
		STAT_FULL    = 2'd3
	} stat_t;

	// code byte number to memory address, wrapping when the table is small
	typedef logic [ADDR_W-1:0] byte_map_t [CODE_BYTES];

	function automatic byte_map_t build_byte_map();
		byte_map_t m;
		for (int i = 0; i < CODE_BYTES; i++) begin
			m[i] = ADDR_W'(i % TABLE_BYTES);
		end
		return m;
	endfunction

	localparam byte_map_t BYTE_MAP = build_byte_map();

endpackage

// ===== rtl/cba_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/code_bitmap_allocator_unit.sv =====
// check, reserve and free read the addressed byte and retire from the look state;
//   allocate reads byte zero, then the next byte for each full byte skipped
// throughput: one request at a time, one bitmap byte read per cycle through the
//   single read port; a new request is taken while the last result waits
// reset: after arst_n the bitmap ram is swept to zero, one byte per cycle over
//   the 128 reachable bytes, with in_ready low; then the unit goes idle
// depends on cba_pkg and cba_ram
module code_bitmap_allocator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic [cba_pkg::CODE_W-1:0] code,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [cba_pkg::CODE_W-1:0] result_code,
	output logic                       was_reserved
);

	import cba_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,   // post-reset sweep of the bitmap ram
		S_IDLE,    // waiting for a request
		S_LOOK,    // read data of the addressed byte is back
		S_SCAN     // allocate: walking bytes upward
	} state_t;

	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_BYTES - 1);

	state_t              state_q;
	logic [SCAN_W-1:0]   scan_q;      // scan byte, also the clear pointer
	req_t                req_q;
	logic [CODE_W-1:0]   code_q;
	logic [ADDR_W-1:0]   addr_q;      // mapped byte of the requested code

	logic                out_valid_q;
	stat_t               status_q;
	logic [CODE_W-1:0]   result_code_q;
	logic                was_reserved_q;

	// ram ports
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [BYTE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	logic                in_accept;
	logic                out_free;
	logic                res_load;
	logic [ADDR_W-1:0]   in_addr;
	logic [ADDR_W-1:0]   scan_addr;

	// check, reserve, free datapath
	logic [BYTE_W-1:0]   bit_mask;
	logic                look_prev;
	stat_t               look_status;
	logic                look_we;
	logic [BYTE_W-1:0]   look_byte;

	// allocate datapath
	logic                scan_found;
	logic [BIT_W-1:0]    zero_bit;
	logic [BYTE_W-1:0]   alloc_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	// the result register can take a new result this cycle
	assign out_free  = !out_valid_q || out_ready;

	// a finished request moves into the result register this cycle
	assign res_load  = out_free && ((state_q == S_LOOK) ||
		(state_q == S_SCAN && (scan_found || scan_q == SCAN_LAST)));

	assign in_addr   = BYTE_MAP[code[CODE_W-1:BIT_W]];
	assign scan_addr = ADDR_W'(scan_q);

	// addressed bit of the byte that just came back
	assign bit_mask  = BYTE_W'(1) << code_q[BIT_W-1:0];
	assign look_prev = |(ram_rdata & bit_mask);

	always_comb begin
		look_status = STAT_OK;
		look_we     = 1'b0;
		look_byte   = ram_rdata;
		unique case (req_q)
			REQ_CHECK: begin
				look_status = STAT_OK;
			end
			REQ_RESERVE: begin
				if (look_prev) begin
					look_status = STAT_ALREADY;
				end else begin
					look_we   = 1'b1;
					look_byte = ram_rdata | bit_mask;
				end
			end
			REQ_FREE: begin
				if (look_prev) begin
					look_we   = 1'b1;
					look_byte = ram_rdata & ~bit_mask;
				end else begin
					look_status = STAT_NOT_RES;
				end
			end
			REQ_ALLOC: begin
				// allocate never passes through the look state
				look_status = STAT_OK;
			end
		endcase
	end

	// lowest clear bit of the scanned byte
	assign scan_found = (ram_rdata != FULL_BYTE);

	always_comb begin
		zero_bit = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				zero_bit = BIT_W'(i);
			end
		end
	end

	assign alloc_byte = ram_rdata | (BYTE_W'(1) << zero_bit);

	// read port: the addressed byte on acceptance, else the next scan byte
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = scan_addr + ADDR_W'(1);
		if (in_accept) begin
			ram_re    = 1'b1;
			ram_raddr = (req_t'(req_type) == REQ_ALLOC) ? '0 : in_addr;
		end else if (state_q == S_SCAN && !scan_found && scan_q != SCAN_LAST) begin
			ram_re = 1'b1;
		end
	end

	// write port: the writeback lands in the cycle the request retires, so the
	// next request, taken in idle at the earliest, reads the updated byte
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = scan_addr;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_LOOK: begin
				ram_we    = look_we && out_free;
				ram_waddr = addr_q;
				ram_wdata = look_byte;
			end
			S_SCAN: begin
				ram_we    = scan_found && out_free;
				ram_wdata = alloc_byte;
			end
			S_IDLE: begin
				ram_we = 1'b0;
			end
		endcase
	end

	cba_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_BYTES)
	) u_bitmap_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			scan_q         <= '0;
			req_q          <= REQ_CHECK;
			code_q         <= '0;
			addr_q         <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= STAT_OK;
			result_code_q  <= '0;
			was_reserved_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (scan_q == SCAN_LAST) begin
						scan_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + SCAN_W'(1);
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						req_q  <= req_t'(req_type);
						code_q <= code;
						addr_q <= in_addr;
						scan_q <= '0;
						state_q <= (req_t'(req_type) == REQ_ALLOC) ? S_SCAN : S_LOOK;
					end
				end
				S_LOOK: begin
					if (out_free) begin
						status_q       <= look_status;
						result_code_q  <= code_q;
						was_reserved_q <= look_prev;
						state_q        <= S_IDLE;
					end
				end
				S_SCAN: begin
					priority if (scan_found) begin
						if (out_free) begin
							status_q       <= STAT_OK;
							result_code_q  <= CODE_W'({scan_q, zero_bit});
							was_reserved_q <= 1'b0;
							state_q        <= S_IDLE;
						end
					end else if (scan_q == SCAN_LAST) begin
						// every reachable byte full: byte zero was full too,
						// so code zero reads as reserved
						if (out_free) begin
							status_q       <= STAT_FULL;
							result_code_q  <= '0;
							was_reserved_q <= 1'b1;
							state_q        <= S_IDLE;
						end
					end else begin
						scan_q <= scan_q + SCAN_W'(1);
					end
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_code  = result_code_q;
	assign was_reserved = was_reserved_q;

endmodule

// ===== rtl/cba_checker.sv =====
// port-level checker for the code bitmap allocator, bound to the top level
// depends on cba_pkg and code_bitmap_allocator_unit
module cba_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic [cba_pkg::CODE_W-1:0] code,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [1:0]                 status,
	input  logic [cba_pkg::CODE_W-1:0] result_code,
	input  logic                       was_reserved
);

	import cba_pkg::*;

	logic              in_acc;
	logic              out_acc;
	logic [1:0]        pend_q;
	logic [1:0]        req_q;
	logic [CODE_W-1:0] code_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests accepted whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_type;
			code_q <= code;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(status) && $stable(result_code) && $stable(was_reserved))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request taken while another is in flight");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a request");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pend_q == 2'd1 && status == STAT_FULL |->
			req_q == REQ_ALLOC && result_code == '0 && was_reserved)
		else $error("bad full result");

	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pend_q == 2'd1 && req_q != REQ_ALLOC |->
			result_code == code_q &&
			(status == STAT_OK ||
			 (status == STAT_ALREADY && req_q == REQ_RESERVE && was_reserved) ||
			 (status == STAT_NOT_RES && req_q == REQ_FREE && !was_reserved)))
		else $error("bad check, reserve or free result");

endmodule

bind code_bitmap_allocator_unit cba_checker u_cba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.req_type     (req_type),
	.code         (code),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.result_code  (result_code),
	.was_reserved (was_reserved)
);
